// ===== hdl/swlf_pkg.sv =====
package swlf_pkg;

	typedef struct packed {
		logic [15:0] delta_x;
		logic signed [31:0] sample;
	} swlf_in_t;

	typedef struct packed {
		logic signed [31:0] slope;
		logic signed [31:0] fitted_value;
		logic [30:0] mean_abs_residual;
		logic fit_valid;
	} swlf_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_APPEND,
		ST_SUM,
		ST_PROD,
		ST_DIV,
		ST_FIT,
		ST_RES,
		ST_MEAN,
		ST_OUT
	} swlf_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic shift_step;
		logic append;
		logic clr_acc;
		logic sum_step;
		logic prod_start;
		logic prod_step;
		logic div_start;
		logic div_step;
		logic div_sel;
		logic commit;
		logic fit_calc;
		logic res_step;
		logic mean_start;
		logic mean_step;
		logic out_load;
	} swlf_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_shift;
		logic idx_last;
		logic prod_done;
		logic div_done;
		logic mean_done;
	} swlf_stat_t;

	localparam int WL_BITS = 6;
	localparam int NUM_BITS = 128;

endpackage

// ===== hdl/sliding_window_line_fit_core.sv =====
// Sliding-window least-squares line fit.
// Input channel in_valid/in_stall carries in_item (delta_x, sample Q16.16).
// Output channel out_valid/out_stall carries out_item (slope, fitted_value,
// mean_abs_residual, fit_valid). One result per input item.
// cfg_we/cfg_data write the window length; writing empties the window.
// One item at a time: one pass of the window each for the sums and residuals,
// two bit-serial divisions for the fit (slope, then intercept) and a
// bit-serial residual mean. Once the window is full, the oldest entry is
// dropped first and the remaining positions are rebased.
// The finished result sits in the output register; the next item is taken
// while it waits, and only the final load waits on a stalled receiver.
// Reset empties the window, zeroes the held line and sets the length to 32.
module sliding_window_line_fit_core
	import swlf_pkg::*;
#(
	parameter int WINDOW = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [WL_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  swlf_in_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output swlf_out_t out_item
);

	swlf_cmd_t cmd;
	swlf_stat_t stat;
	logic ov_q;

	swlf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_full(ov_q && out_stall), .stat(stat), .cmd(cmd)
	);

	swlf_dp #(.WINDOW(WINDOW)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_len(cfg_data),
		.in_item(in_item), .cmd(cmd), .stat(stat), .res(out_item)
	);

	// Hold output valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.out_load) ov_q <= 1'b1;
		else if (!out_stall) ov_q <= 1'b0;
	end
	assign out_valid = ov_q;

endmodule

// ===== hdl/swlf_ctrl.sv =====
module swlf_ctrl
	import swlf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic out_full,
	input  swlf_stat_t stat,
	output swlf_cmd_t cmd
);

	swlf_state_t state_q, state_d;
	logic sel_q, sel_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
		end
	end

	// Sequence one item through the datapath
	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cmd = '0;
		cmd.div_sel = sel_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = stat.need_shift ? ST_SHIFT : ST_APPEND;
				end
			end
			ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.idx_last) state_d = ST_APPEND;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				cmd.clr_acc = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (stat.idx_last) begin
					cmd.prod_start = 1'b1;
					state_d = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod_step = 1'b1;
				if (stat.prod_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = 1'b0;
					sel_d = 1'b0;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					if (!sel_q) begin
						sel_d = 1'b1;
						cmd.div_start = 1'b1;
						cmd.div_sel = 1'b1;
					end else begin
						state_d = ST_FIT;
					end
				end
			end
			ST_FIT: begin
				cmd.commit = 1'b1;
				state_d = ST_RES;
			end
			ST_RES: begin
				if (sel_q) begin
					cmd.fit_calc = 1'b1;
					sel_d = 1'b0;
				end else begin
					cmd.res_step = 1'b1;
					if (stat.idx_last) begin
						cmd.mean_start = 1'b1;
						state_d = ST_MEAN;
					end
				end
			end
			ST_MEAN: begin
				cmd.mean_step = 1'b1;
				if (stat.mean_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_full) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/swlf_dp.sv =====
module swlf_dp
	import swlf_pkg::*;
#(
	parameter int WINDOW = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [WL_BITS-1:0] cfg_len,
	input  swlf_in_t in_item,
	input  swlf_cmd_t cmd,
	output swlf_stat_t stat,
	output swlf_out_t res
);

	localparam int IW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	// Relative positions span at most WINDOW - 1 steps of 16 bits
	localparam int POS_BITS = IW + 16;

	// Window storage
	logic [POS_BITS-1:0] pos_mem [WINDOW];
	logic signed [31:0] smp_mem [WINDOW];

	logic [WL_BITS-1:0] wlen_q;
	logic [CW-1:0] len_eff, vcnt_q, n_q;
	logic [CW-1:0] idx_q;
	logic [15:0] dx_q;
	logic signed [31:0] y_q;
	logic [POS_BITS-1:0] base_q, last_pos_q, newpos_q;
	logic signed [31:0] slope_q;
	logic signed [47:0] icpt_q;

	// Clamp requested length
	always_comb begin
		if (wlen_q < 6'd2) len_eff = CW'(2);
		else if ({{(32-WL_BITS){1'b0}}, wlen_q} > WINDOW) len_eff = CW'(WINDOW);
		else len_eff = CW'(wlen_q);
	end

	logic [CW-1:0] vc_clamped;
	assign vc_clamped = (vcnt_q > len_eff) ? len_eff : vcnt_q;
	assign stat.need_shift = (vc_clamped == len_eff);

	// Sums
	logic signed [63:0] sxx_q, sx_q, sxy_q, sy_q;
	logic [POS_BITS-1:0] rd_pos;
	logic signed [31:0] rd_smp;
	assign rd_pos = pos_mem[idx_q[IW-1:0]];
	assign rd_smp = smp_mem[idx_q[IW-1:0]];

	logic [CW-1:0] idx_end;
	always_comb begin
		if (cmd.shift_step) idx_end = len_eff - CW'(2);
		else idx_end = n_q - CW'(1);
	end
	assign stat.idx_last = (idx_q == idx_end);

	// Products: sequenced 64x64 via 32-bit partials
	logic [2:0] pstep_q;
	logic signed [127:0] den_w_q, nk_q, nb_q;
	logic signed [127:0] pa_q;
	logic signed [63:0] mx_a, mx_b;
	logic signed [127:0] prod;
	always_comb begin
		case (pstep_q)
			3'd0: begin mx_a = 64'(n_q); mx_b = sxx_q; end
			3'd1: begin mx_a = sx_q; mx_b = sx_q; end
			3'd2: begin mx_a = 64'(n_q); mx_b = sxy_q; end
			3'd3: begin mx_a = sx_q; mx_b = sy_q; end
			3'd4: begin mx_a = sxx_q; mx_b = sy_q; end
			default: begin mx_a = sx_q; mx_b = sxy_q; end
		endcase
	end
	// Sums stay within 64 bits, so a 64x64 product splits into four 32x32 partials, registered and then summed
	logic [63:0] ma, mb;
	logic [127:0] mag_p;
	assign ma = mx_a[63] ? 64'(-mx_a) : 64'(mx_a);
	assign mb = mx_b[63] ? 64'(-mx_b) : 64'(mx_b);
	logic [63:0] p00, p01, p10, p11;
	assign p00 = 64'(ma[31:0]) * 64'(mb[31:0]);
	assign p01 = 64'(ma[31:0]) * 64'(mb[63:32]);
	assign p10 = 64'(ma[63:32]) * 64'(mb[31:0]);
	assign p11 = 64'(ma[63:32]) * 64'(mb[63:32]);
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;
	logic neg_s1;
	logic [2:0] pstep_s1;
	logic pv_s1;
	assign mag_p = {64'd0, p00_s1} + ({64'd0, p01_s1} << 32) + ({64'd0, p10_s1} << 32)
		+ {p11_s1, 64'd0};
	assign prod = neg_s1 ? -$signed(mag_p) : $signed(mag_p);
	assign stat.prod_done = pv_s1 && (pstep_s1 == 3'd5);

	// Divider: restoring, one bit per cycle
	logic [127:0] dnum_q;
	logic [63:0] drem_q, dq_q;
	logic [63:0] dden_q;
	logic dneg_q, dover_q;
	logic [7:0] dcnt_q;
	logic [64:0] rem_sh;
	logic [64:0] rem_sub;
	assign rem_sh = {drem_q, dnum_q[127]};
	assign rem_sub = rem_sh - {1'b0, dden_q};
	assign stat.div_done = (dcnt_q == 8'd128);

	logic [63:0] qr;
	logic qover;
	logic [64:0] rrem;
	always_comb begin
		rrem = {1'b0, dden_q} - {1'b0, drem_q};
		qr = dq_q;
		qover = dover_q;
		if (drem_q >= rrem[63:0]) begin
			if (dq_q == '1) qover = 1'b1;
			else qr = dq_q + 64'd1;
		end
	end
	logic den_ok_q;

	logic signed [31:0] div_slope;
	logic signed [47:0] div_icpt;
	always_comb begin
		if (dneg_q) begin
			div_slope = (qover || qr > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-qr);
			div_icpt = (qover || qr > 64'h8000_0000_0000) ? 48'sh8000_0000_0000 : 48'(-qr);
		end else begin
			div_slope = (qover || qr > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(qr);
			div_icpt = (qover || qr > 64'h7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF : 48'(qr);
		end
	end
	logic signed [31:0] new_slope_q;

	// Residual path
	logic signed [80:0] lin_full;
	logic signed [POS_BITS+32:0] lin_prod;
	logic [POS_BITS-1:0] lin_x;
	assign lin_x = cmd.fit_calc ? newpos_q : rd_pos;
	assign lin_prod = slope_q * $signed({1'b0, lin_x});
	assign lin_full = 81'(lin_prod) + 81'(icpt_q);
	logic signed [81:0] dres;
	assign dres = 82'(lin_full) - 82'(rd_smp);
	logic [87:0] rsum_q;
	logic signed [31:0] fit_q;
	logic fv_q;

	// Mean: divide rsum by n, one bit per cycle
	logic [87:0] mnum_q, mq_q;
	logic [CW:0] mrem_q;
	logic [6:0] mcnt_q;
	logic [CW+1:0] mrem_sh, mrem_sub;
	assign mrem_sh = {mrem_q, mnum_q[87]};
	assign mrem_sub = mrem_sh - (CW+2)'(n_q);
	assign stat.mean_done = (mcnt_q == 7'd88);
	logic [CW+1:0] mrr;
	logic [87:0] mean_r;
	assign mrr = (CW+2)'(n_q) - (CW+2)'(mrem_q);
	assign mean_r = ((CW+2)'(mrem_q) >= mrr) ? mq_q + 88'd1 : mq_q;

	// Hold window and arithmetic state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= 6'd32;
			vcnt_q <= '0;
			slope_q <= '0;
			icpt_q <= '0;
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.prod_step;
			if (cfg_we) begin
				wlen_q <= cfg_len;
				vcnt_q <= '0;
			end
			if (cmd.load_in) vcnt_q <= stat.need_shift ? len_eff - CW'(1) : vc_clamped;
			if (cmd.append) vcnt_q <= vcnt_q + CW'(1);
			if (cmd.commit && den_ok_q) begin
				slope_q <= new_slope_q;
				icpt_q <= div_icpt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			dx_q <= in_item.delta_x;
			y_q <= in_item.sample;
			idx_q <= '0;
			base_q <= pos_mem[1];
			last_pos_q <= (vc_clamped == '0) ? '0 : pos_mem[IW'(vc_clamped - CW'(1))];
		end
		// Drop oldest pair and rebase positions
		if (cmd.shift_step) begin
			pos_mem[idx_q[IW-1:0]] <= pos_mem[IW'(idx_q + CW'(1))] - base_q;
			smp_mem[idx_q[IW-1:0]] <= smp_mem[IW'(idx_q + CW'(1))];
			idx_q <= stat.idx_last ? '0 : idx_q + CW'(1);
			if (idx_q == '0) last_pos_q <= pos_mem[IW'(len_eff - CW'(1))] - base_q;
		end
		if (cmd.append) begin
			newpos_q <= (vcnt_q == '0) ? '0 : last_pos_q + POS_BITS'(dx_q);
			pos_mem[IW'(vcnt_q)] <= (vcnt_q == '0) ? '0 : last_pos_q + POS_BITS'(dx_q);
			smp_mem[IW'(vcnt_q)] <= y_q;
			n_q <= vcnt_q + CW'(1);
			idx_q <= '0;
		end
		if (cmd.clr_acc) begin
			sxx_q <= '0; sx_q <= '0; sxy_q <= '0; sy_q <= '0;
		end
		// Accumulate one entry per cycle
		if (cmd.sum_step) begin
			sxx_q <= sxx_q + 64'(64'(rd_pos) * 64'(rd_pos));
			sx_q <= sx_q + 64'(rd_pos);
			sxy_q <= sxy_q + 64'($signed({1'b0, rd_pos})) * 64'(rd_smp);
			sy_q <= sy_q + 64'(rd_smp);
			idx_q <= stat.idx_last ? '0 : idx_q + CW'(1);
		end
		if (cmd.prod_start) pstep_q <= '0;
		if (cmd.prod_step && pstep_q != 3'd5) pstep_q <= pstep_q + 3'd1;
		p00_s1 <= p00; p01_s1 <= p01; p10_s1 <= p10; p11_s1 <= p11;
		neg_s1 <= mx_a[63] ^ mx_b[63];
		pstep_s1 <= pstep_q;
		if (pv_s1) begin
			case (pstep_s1)
				3'd0: den_w_q <= prod;
				3'd1: den_w_q <= den_w_q - prod;
				3'd2: pa_q <= prod;
				3'd3: nk_q <= pa_q - prod;
				3'd4: pa_q <= prod;
				default: nb_q <= pa_q - prod;
			endcase
		end
		// Slope division first, intercept second
		if (cmd.div_start) begin
			dnum_q <= cmd.div_sel ? (nb_q[127] ? 128'(-nb_q) : nb_q)
				: (nk_q[127] ? 128'(-nk_q) : nk_q);
			dneg_q <= cmd.div_sel ? nb_q[127] : nk_q[127];
			dden_q <= den_w_q[63:0];
			den_ok_q <= (n_q >= CW'(2)) && !den_w_q[127] && (den_w_q != '0);
			drem_q <= '0; dq_q <= '0; dover_q <= 1'b0; dcnt_q <= '0;
		end else if (cmd.div_step && !stat.div_done) begin
			dnum_q <= dnum_q << 1;
			if (dq_q[63]) dover_q <= 1'b1;
			if (!rem_sub[64]) begin
				drem_q <= rem_sub[63:0];
				dq_q <= {dq_q[62:0], 1'b1};
			end else begin
				drem_q <= rem_sh[63:0];
				dq_q <= {dq_q[62:0], 1'b0};
			end
		end
		// Capture the slope quotient as the intercept division starts
		if (cmd.div_start && cmd.div_sel) new_slope_q <= div_slope;
		if (cmd.commit) begin
			fv_q <= den_ok_q;
			rsum_q <= '0;
			idx_q <= '0;
		end
		if (cmd.fit_calc) begin
			if (lin_full > 81'sh7FFF_FFFF) fit_q <= 32'sh7FFF_FFFF;
			else if (lin_full < -81'sh8000_0000) fit_q <= 32'sh8000_0000;
			else fit_q <= lin_full[31:0];
		end
		if (cmd.res_step) begin
			rsum_q <= rsum_q + 88'(dres[81] ? -dres : dres);
			idx_q <= stat.idx_last ? '0 : idx_q + CW'(1);
		end
		if (cmd.mean_start) begin
			mnum_q <= cmd.res_step ? rsum_q + 88'(dres[81] ? -dres : dres) : rsum_q;
			mrem_q <= '0; mq_q <= '0; mcnt_q <= '0;
		end else if (cmd.mean_step && !stat.mean_done) begin
			mnum_q <= mnum_q << 1;
			mcnt_q <= mcnt_q + 7'd1;
			if (!mrem_sub[CW+1]) begin
				mrem_q <= mrem_sub[CW:0];
				mq_q <= {mq_q[86:0], 1'b1};
			end else begin
				mrem_q <= mrem_sh[CW:0];
				mq_q <= {mq_q[86:0], 1'b0};
			end
		end
		if (cmd.div_step && !stat.div_done && !cmd.div_start) dcnt_q <= dcnt_q + 8'd1;
		if (cmd.out_load) begin
			res.slope <= slope_q;
			res.fitted_value <= fit_q;
			res.mean_abs_residual <= (mean_r > 88'h7FFF_FFFF) ? 31'h7FFF_FFFF : mean_r[30:0];
			res.fit_valid <= fv_q;
		end
	end

	// Divider never exceeds its bit count
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= 8'd128 || $isunknown(dcnt_q)) else $error("divider overrun");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> vcnt_q < len_eff) else $error("window overfull");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.shift_step, cmd.sum_step, cmd.res_step, cmd.mean_step}))
		else $error("datapath ops overlap");

endmodule
